[rtl/core/rttt_pkg.sv]
// ----------------------------------------------------------------------------
// Retransmission timer table package
// Shared codes, defaults and the types that pass between the core's modules.
// ----------------------------------------------------------------------------
package rttt_pkg;

	localparam int DEF_TABLE_DEPTH   = 16;
	localparam int DEF_CHANNEL_COUNT = 8;

	localparam int IN_TDATA_W  = 168;
	localparam int OUT_TDATA_W = 104;

	localparam logic [31:0] SLEEP_NONE = 32'h7fff_ffff;

	// Input item kinds.
	localparam logic [1:0] K_SEND = 2'd0;
	localparam logic [1:0] K_RECV = 2'd1;
	localparam logic [1:0] K_ACK  = 2'd2;
	localparam logic [1:0] K_TICK = 2'd3;

	// Result kinds.
	localparam logic [2:0] RK_RETX   = 3'd0;
	localparam logic [2:0] RK_NAK    = 3'd1;
	localparam logic [2:0] RK_IACK   = 3'd2;
	localparam logic [2:0] RK_CANCEL = 3'd3;
	localparam logic [2:0] RK_SLEEP  = 3'd4;
	localparam logic [2:0] RK_FULL   = 3'd5;

	// Configuration register indexes.
	localparam logic CFG_OWN_NODE    = 1'b0;
	localparam logic CFG_RETRY_LIMIT = 1'b1;

	localparam logic [3:0] RETRY_LIMIT_RST = 4'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] from_node;
		logic [31:0] to_node;
		logic [31:0] packet_id;
		logic        ack_req;
		logic [2:0]  channel;
		logic [15:0] airtime_ms;
		logic [15:0] retry_delay_ms;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [31:0] origin_node;
		logic [31:0] out_packet_id;
		logic [2:0]  out_channel;
		logic [31:0] sleep_ms;
	} res_t;

	typedef struct packed {
		logic       load;
		logic       scan;
		logic       stop;
		logic       tick_retx;
		logic       tick_keep;
		logic       write_new;
		logic       push;
		logic [2:0] rkind;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       want;
		logic       match_found;
		logic       alloc_ok;
		logic       e_valid;
		logic       e_due;
		logic       e_rzero;
		logic       e_cancel;
	} sts_t;

endpackage

[rtl/core/rttt_obuf.sv]
// ----------------------------------------------------------------------------
// Result output buffer
// Holds the newest result until the next one or the end of the item shows
// whether it is the last, and drives the output stream register.
// ----------------------------------------------------------------------------
module rttt_obuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic          finish,
	input  rttt_pkg::res_t res,
	output logic          rdy,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [rttt_pkg::OUT_TDATA_W-1:0] m_tdata, // origin, id, channel, sleep
	output logic [2:0]    m_tuser,  // result_kind
	output logic          m_tlast
);
	import rttt_pkg::*;

	res_t p_q;
	logic p_vld_q;
	res_t o_q;
	logic o_last_q;
	logic o_vld_q;
	logic taken;

	assign taken = o_vld_q && m_tready;
	assign rdy   = !p_vld_q || !o_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_vld_q <= 1'b0;
			o_vld_q <= 1'b0;
		end else begin
			if (taken)
				o_vld_q <= 1'b0;
			if ((push || finish) && p_vld_q)
				o_vld_q <= 1'b1;
			if (push)
				p_vld_q <= 1'b1;
			else if (finish)
				p_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((push || finish) && p_vld_q) begin
			o_q      <= p_q;
			o_last_q <= finish;
		end
		if (push)
			p_q <= res;
	end

	assign m_tvalid = o_vld_q;
	assign m_tuser  = o_q.result_kind;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {5'd0, o_q.sleep_ms, o_q.out_channel, o_q.out_packet_id,
		o_q.origin_node};

endmodule

[rtl/core/rttt_dp.sv]
// ----------------------------------------------------------------------------
// Retransmission timer table datapath
// Entry table, item registers, configuration, key search and sleep minimum.
// ----------------------------------------------------------------------------
module rttt_dp #(
	parameter int TABLE_DEPTH   = rttt_pkg::DEF_TABLE_DEPTH,
	parameter int CHANNEL_COUNT = rttt_pkg::DEF_CHANNEL_COUNT,
	parameter int IW            = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [31:0]      cfg_data,
	input  rttt_pkg::item_t  item,
	input  rttt_pkg::cmd_t   cmd,
	input  logic [IW-1:0]    idx,
	output rttt_pkg::sts_t   sts,
	output logic [IW-1:0]    match_idx,
	output rttt_pkg::res_t   res
);
	import rttt_pkg::*;

	logic        v_q     [TABLE_DEPTH];
	logic [31:0] org_q   [TABLE_DEPTH];
	logic [31:0] id_q    [TABLE_DEPTH];
	logic [2:0]  ch_q    [TABLE_DEPTH];
	logic [3:0]  rtr_q   [TABLE_DEPTH];
	logic [31:0] ns_q    [TABLE_DEPTH];
	logic [15:0] dly_q   [TABLE_DEPTH];

	logic [31:0] own_q;
	logic [3:0]  lim_q;

	logic [1:0]  kind_q;
	logic        want_q;
	logic        key_en_q;
	logic [31:0] key_q;
	logic [31:0] pid_q;
	logic [2:0]  chn_q;
	logic [15:0] air_q;
	logic [15:0] rdel_q;
	logic [31:0] now_q;
	logic [31:0] d_q;
	logic        mfound_q;
	logic [IW-1:0] midx_q;
	logic        ffound_q;
	logic [IW-1:0] fidx_q;

	logic        e_v;
	logic [31:0] e_org, e_id, e_ns;
	logic [2:0]  e_ch;
	logic [3:0]  e_rtr;
	logic [15:0] e_dly;
	logic        e_match;
	logic        air_hit;
	logic [IW-1:0] aidx;
	logic [31:0] cand;
	logic [31:0] ld_org;
	logic        ld_key_en;
	logic [31:0] ld_key;

	assign e_v   = v_q[idx];
	assign e_org = org_q[idx];
	assign e_id  = id_q[idx];
	assign e_ns  = ns_q[idx];
	assign e_ch  = ch_q[idx];
	assign e_rtr = rtr_q[idx];
	assign e_dly = dly_q[idx];

	assign e_match = e_v && (e_org == key_q) && (e_id == pid_q);
	assign air_hit = e_v && (((kind_q == K_SEND) && (e_id != pid_q)) || (kind_q == K_RECV));
	assign aidx    = (mfound_q && (!ffound_q || (midx_q < fidx_q))) ? midx_q : fidx_q;
	assign cand    = cmd.tick_retx ? {16'd0, e_dly} : (e_ns - now_q);

	always_comb begin
		ld_org    = (item.from_node == 32'd0) ? own_q : item.from_node;
		ld_key    = item.to_node;
		ld_key_en = 1'b0;
		case (item.kind)
			K_SEND: begin
				ld_key    = ld_org;
				ld_key_en = item.ack_req;
			end
			K_RECV: begin
				ld_key    = item.from_node;
				ld_key_en = (item.from_node == own_q);
			end
			K_ACK: begin
				ld_key_en = (item.to_node == own_q) && (item.packet_id != 32'd0);
			end
			default: ld_key_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= 32'd0;
			lim_q <= RETRY_LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_OWN_NODE)
				own_q <= cfg_data;
			else if (cfg_index == CFG_RETRY_LIMIT)
				lim_q <= cfg_data[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				v_q[i] <= 1'b0;
		end else begin
			if (cmd.stop)
				v_q[idx] <= 1'b0;
			if (cmd.write_new)
				v_q[aidx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= item.kind;
			want_q   <= item.ack_req;
			key_en_q <= ld_key_en;
			key_q    <= ld_key;
			pid_q    <= item.packet_id;
			chn_q    <= ({29'd0, item.channel} >= 32'(CHANNEL_COUNT)) ? 3'd0 : item.channel;
			air_q    <= item.airtime_ms;
			rdel_q   <= item.retry_delay_ms;
			now_q    <= item.now_ms;
			d_q      <= SLEEP_NONE;
			mfound_q <= 1'b0;
			ffound_q <= 1'b0;
		end
		if (cmd.scan) begin
			if (air_hit)
				ns_q[idx] <= e_ns + {16'd0, air_q};
			if (key_en_q && e_match && !mfound_q) begin
				mfound_q <= 1'b1;
				midx_q   <= idx;
			end
			if ((kind_q == K_SEND) && !e_v && !ffound_q) begin
				ffound_q <= 1'b1;
				fidx_q   <= idx;
			end
		end
		if (cmd.tick_retx) begin
			rtr_q[idx] <= e_rtr - 4'd1;
			ns_q[idx]  <= now_q + {16'd0, e_dly};
		end
		if ((cmd.tick_retx || cmd.tick_keep) && ($signed(cand) < $signed(d_q)))
			d_q <= cand;
		if (cmd.write_new) begin
			org_q[aidx] <= key_q;
			id_q[aidx]  <= pid_q;
			ch_q[aidx]  <= chn_q;
			rtr_q[aidx] <= (lim_q != 4'd0) ? lim_q - 4'd1 : 4'd0;
			dly_q[aidx] <= rdel_q;
			ns_q[aidx]  <= now_q + {16'd0, rdel_q};
		end
	end

	always_comb begin
		sts.kind        = kind_q;
		sts.want        = want_q;
		sts.match_found = mfound_q;
		sts.alloc_ok    = mfound_q || ffound_q;
		sts.e_valid     = e_v;
		sts.e_due       = e_ns <= now_q;
		sts.e_rzero     = e_rtr == 4'd0;
		sts.e_cancel    = ({1'b0, e_rtr} + 5'd1) < {1'b0, lim_q};
	end
	assign match_idx = midx_q;

	always_comb begin
		res.result_kind   = cmd.rkind;
		res.origin_node   = e_org;
		res.out_packet_id = e_id;
		res.out_channel   = e_ch;
		res.sleep_ms      = 32'd0;
		case (cmd.rkind)
			RK_FULL: begin
				res.origin_node   = key_q;
				res.out_packet_id = pid_q;
				res.out_channel   = chn_q;
			end
			RK_SLEEP: begin
				res.origin_node   = 32'd0;
				res.out_packet_id = 32'd0;
				res.out_channel   = 3'd0;
				res.sleep_ms      = d_q;
			end
			default: res.sleep_ms = 32'd0;
		endcase
	end

endmodule

[rtl/core/rttt_ctrl.sv]
// ----------------------------------------------------------------------------
// Retransmission timer table controller
// Sequences the table walk for each item and issues datapath commands.
// ----------------------------------------------------------------------------
module rttt_ctrl #(
	parameter int TABLE_DEPTH = rttt_pkg::DEF_TABLE_DEPTH,
	parameter int IW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [1:0]      in_kind,
	input  rttt_pkg::sts_t  sts,
	input  logic [IW-1:0]   match_idx,
	input  logic            rdy,
	output rttt_pkg::cmd_t  cmd,
	output logic [IW-1:0]   idx
);
	import rttt_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SCAN  = 4'd1;
	localparam logic [3:0] ST_POST  = 4'd2;
	localparam logic [3:0] ST_ACK   = 4'd3;
	localparam logic [3:0] ST_STOP  = 4'd4;
	localparam logic [3:0] ST_ALLOC = 4'd5;
	localparam logic [3:0] ST_TICK  = 4'd6;
	localparam logic [3:0] ST_SLEEP = 4'd7;
	localparam logic [3:0] ST_FIN   = 4'd8;

	logic [3:0]    state_q, state_d;
	logic [IW-1:0] cnt_q, cnt_d;
	logic          at_end;

	assign at_end   = cnt_q == IW'(TABLE_DEPTH - 1);
	assign s_tready = state_q == ST_IDLE;

	always_comb begin
		if (state_q == ST_ACK || (state_q == ST_STOP && sts.kind != K_TICK))
			idx = match_idx;
		else
			idx = cnt_q;
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = (in_kind == K_TICK) ? ST_TICK : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (at_end)
					state_d = ST_POST;
				else
					cnt_d = cnt_q + 1'b1;
			end
			ST_POST: begin
				state_d = ST_FIN;
				case (sts.kind)
					K_SEND: begin
						if (sts.want)
							state_d = sts.match_found ? ST_STOP : ST_ALLOC;
					end
					K_RECV: begin
						if (sts.match_found)
							state_d = ST_ACK;
					end
					K_ACK: begin
						if (sts.match_found)
							state_d = ST_STOP;
					end
					default: state_d = ST_FIN;
				endcase
			end
			ST_ACK: begin
				if (rdy) begin
					cmd.push  = 1'b1;
					cmd.rkind = RK_IACK;
					state_d   = ST_STOP;
				end
			end
			ST_STOP: begin
				if (!sts.e_cancel || rdy) begin
					cmd.stop  = 1'b1;
					cmd.push  = sts.e_cancel;
					cmd.rkind = RK_CANCEL;
					if (sts.kind == K_TICK) begin
						if (at_end)
							state_d = ST_SLEEP;
						else begin
							cnt_d   = cnt_q + 1'b1;
							state_d = ST_TICK;
						end
					end else if (sts.kind == K_SEND)
						state_d = ST_ALLOC;
					else
						state_d = ST_FIN;
				end
			end
			ST_ALLOC: begin
				if (sts.alloc_ok) begin
					cmd.write_new = 1'b1;
					state_d       = ST_FIN;
				end else if (rdy) begin
					cmd.push  = 1'b1;
					cmd.rkind = RK_FULL;
					state_d   = ST_FIN;
				end
			end
			ST_TICK: begin
				if (sts.e_valid && sts.e_due && sts.e_rzero) begin
					// A give-up nak is followed by the stop of the entry.
					if (rdy) begin
						cmd.push  = 1'b1;
						cmd.rkind = RK_NAK;
						state_d   = ST_STOP;
					end
				end else if (!sts.e_valid || !sts.e_due || rdy) begin
					cmd.tick_retx = sts.e_valid && sts.e_due;
					cmd.tick_keep = sts.e_valid && !sts.e_due;
					cmd.push      = sts.e_valid && sts.e_due;
					cmd.rkind     = RK_RETX;
					if (at_end)
						state_d = ST_SLEEP;
					else
						cnt_d = cnt_q + 1'b1;
				end
			end
			ST_SLEEP: begin
				if (rdy) begin
					cmd.push  = 1'b1;
					cmd.rkind = RK_SLEEP;
					state_d   = ST_FIN;
				end
			end
			ST_FIN: begin
				if (rdy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

[rtl/core/retransmission_timer_table_core.sv]
// An item that causes no result walks every table entry in the scan state, then
// the post and finish states before the next input transfer; a send that asks
// for an ack adds the alloc state, a stopped entry or give-up nak the stop state,
// an implicit ack the ack state, and a stalled output adds the stall. The core
// takes no new item until it is done with the last. Reset (arst_n low) clears all
// valid bits, own_node to 0 and retry_limit to 3; the block is ready at once.
// ----------------------------------------------------------------------------
// Retransmission timer table core
// Table of packets awaiting acknowledgement with retry timers and sleep report.
// ----------------------------------------------------------------------------
module retransmission_timer_table_core #(
	parameter int TABLE_DEPTH   = rttt_pkg::DEF_TABLE_DEPTH,
	parameter int CHANNEL_COUNT = rttt_pkg::DEF_CHANNEL_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// from_node, to_node, packet_id, ack_req, channel, airtime_ms,
	// retry_delay_ms, now_ms
	input  logic [rttt_pkg::IN_TDATA_W-1:0] s_tdata,
	input  logic [1:0]  s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	// origin_node, out_packet_id, out_channel, sleep_ms
	output logic [rttt_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [2:0]  m_tuser,  // result_kind
	output logic        m_tlast
);
	import rttt_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	item_t         item;
	cmd_t          cmd;
	sts_t          sts;
	res_t          res;
	logic [IW-1:0] idx;
	logic [IW-1:0] match_idx;
	logic          rdy;

	always_comb begin
		item.kind           = s_tuser;
		item.from_node      = s_tdata[31:0];
		item.to_node        = s_tdata[63:32];
		item.packet_id      = s_tdata[95:64];
		item.ack_req        = s_tdata[96];
		item.channel        = s_tdata[99:97];
		item.airtime_ms     = s_tdata[115:100];
		item.retry_delay_ms = s_tdata[131:116];
		item.now_ms         = s_tdata[163:132];
	end

	rttt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .IW(IW)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.in_kind(s_tuser), .sts(sts), .match_idx(match_idx), .rdy(rdy),
		.cmd(cmd), .idx(idx)
	);

	rttt_dp #(.TABLE_DEPTH(TABLE_DEPTH), .CHANNEL_COUNT(CHANNEL_COUNT), .IW(IW)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .item(item), .cmd(cmd), .idx(idx), .sts(sts),
		.match_idx(match_idx), .res(res)
	);

	rttt_obuf u_obuf (
		.clk(clk), .arst_n(arst_n), .push(cmd.push), .finish(cmd.finish),
		.res(res), .rdy(rdy), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
	);

endmodule

[rtl/core/rttt_checker.sv]
// ----------------------------------------------------------------------------
// Retransmission timer table port checker
// Watches the core's ports for result and handshake consistency.
// ----------------------------------------------------------------------------
module rttt_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [rttt_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);
	import rttt_pkg::*;

	// One item at a time: the core is busy right after an accepted transfer.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while previous item still in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_sleep_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == RK_SLEEP) |-> m_tlast)
		else $error("sleep report is not the last result");

	a_sleep_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != RK_SLEEP) |-> (m_tdata[98:67] == 32'd0))
		else $error("sleep field set outside a sleep report");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser != 3'd6) && (m_tuser != 3'd7))
		else $error("result kind without meaning");

endmodule

bind retransmission_timer_table_core rttt_port_checks u_port_checks (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
	.m_tuser(m_tuser), .m_tlast(m_tlast)
);

[sim/rttt_checker.sv]
// ----------------------------------------------------------------------------
// Retransmission timer table checker
// Watches the configuration port and both stream channels, keeps its own copy
// of the timer table, predicts the results of every accepted item and compares
// each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module rttt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [rttt_pkg::IN_TDATA_W-1:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [rttt_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        m_tlast,
	output int          errors,
	output int          pending
);
	import rttt_pkg::*;

	localparam int DEPTH = DEF_TABLE_DEPTH;

	typedef struct packed {
		logic [2:0]  rkind;
		logic [31:0] origin;
		logic [31:0] pid;
		logic [2:0]  chan;
		logic [31:0] sleep;
		logic        tlast;
	} outcome_t;

	outcome_t    outcomes[$];
	logic [31:0] my_node;
	logic [3:0]  max_tx;
	logic        t_valid[DEPTH];
	logic [31:0] t_origin[DEPTH];
	logic [31:0] t_id[DEPTH];
	logic [2:0]  t_chan[DEPTH];
	logic [3:0]  t_left[DEPTH];
	logic [31:0] t_next[DEPTH];
	logic [15:0] t_delay[DEPTH];
	int          mismatches;
	int          queued;

	assign errors  = mismatches;
	assign pending = queued;

	function automatic void push_outcome(logic [2:0] k, logic [31:0] o, logic [31:0] p,
			logic [2:0] c, logic [31:0] s);
		outcome_t r;
		r = '{k, o, p, c, s, 1'b0};
		outcomes.push_back(r);
	endfunction

	// Stopping an entry cancels the queued original once it has been on the air.
	function automatic void drop_entry(int i);
		if ({1'b0, t_left[i]} + 5'd1 < {1'b0, max_tx})
			push_outcome(RK_CANCEL, t_origin[i], t_id[i], t_chan[i], 32'd0);
		t_valid[i] = 1'b0;
	endfunction

	function automatic int lookup(logic [31:0] o, logic [31:0] p);
		for (int i = 0; i < DEPTH; i++)
			if (t_valid[i] && t_origin[i] == o && t_id[i] == p)
				return i;
		return -1;
	endfunction

	function automatic void predict_item(item_t it);
		int          before_n;
		int          f;
		logic [31:0] org;
		logic [2:0]  ch;
		logic signed [31:0] best;
		logic signed [31:0] gap;
		before_n = outcomes.size();
		ch = it.channel;
		best = SLEEP_NONE;
		case (it.kind)
			K_SEND: begin
				org = (it.from_node == 0) ? my_node : it.from_node;
				if (it.ack_req) begin
					f = lookup(org, it.packet_id);
					if (f >= 0)
						drop_entry(f);
					f = -1;
					for (int i = 0; i < DEPTH; i++)
						if (!t_valid[i] && f < 0)
							f = i;
					if (f < 0) begin
						push_outcome(RK_FULL, org, it.packet_id, ch, 32'd0);
					end else begin
						t_valid[f] = 1'b1;
						t_origin[f] = org;
						t_id[f] = it.packet_id;
						t_chan[f] = ch;
						t_left[f] = (max_tx > 0) ? max_tx - 4'd1 : 4'd0;
						t_delay[f] = it.retry_delay_ms;
						t_next[f] = it.now_ms + {16'd0, it.retry_delay_ms};
					end
				end
				for (int i = 0; i < DEPTH; i++)
					if (t_valid[i] && t_id[i] != it.packet_id)
						t_next[i] = t_next[i] + {16'd0, it.airtime_ms};
			end
			K_RECV: begin
				if (it.from_node == my_node) begin
					f = lookup(it.from_node, it.packet_id);
					if (f >= 0) begin
						push_outcome(RK_IACK, it.from_node, it.packet_id, t_chan[f], 32'd0);
						drop_entry(f);
					end
				end
				for (int i = 0; i < DEPTH; i++)
					if (t_valid[i])
						t_next[i] = t_next[i] + {16'd0, it.airtime_ms};
			end
			K_ACK: begin
				if (it.to_node == my_node && it.packet_id != 0) begin
					f = lookup(it.to_node, it.packet_id);
					if (f >= 0)
						drop_entry(f);
				end
			end
			default: begin
				for (int i = 0; i < DEPTH; i++) begin
					if (t_valid[i]) begin
						if (t_next[i] <= it.now_ms && t_left[i] == 0) begin
							push_outcome(RK_NAK, t_origin[i], t_id[i], t_chan[i], 32'd0);
							drop_entry(i);
						end else begin
							if (t_next[i] <= it.now_ms) begin
								push_outcome(RK_RETX, t_origin[i], t_id[i], t_chan[i], 32'd0);
								t_left[i] = t_left[i] - 4'd1;
								t_next[i] = it.now_ms + {16'd0, t_delay[i]};
							end
							gap = t_next[i] - it.now_ms;
							if (gap < best)
								best = gap;
						end
					end
				end
				push_outcome(RK_SLEEP, 32'd0, 32'd0, 3'd0, best);
			end
		endcase
		if (outcomes.size() > before_n)
			outcomes[outcomes.size() - 1].tlast = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		item_t    it;
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			my_node = 32'd0;
			max_tx = RETRY_LIMIT_RST;
			for (int i = 0; i < DEPTH; i++)
				t_valid[i] = 1'b0;
			outcomes.delete();
			mismatches = 0;
			queued = 0;
		end else begin
			// Outputs are checked before the same edge's input transfer is predicted.
			if (m_tvalid && m_tready) begin
				got = '{m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[66:64],
					m_tdata[98:67], m_tlast};
				if (outcomes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer: %p", got);
				end else begin
					want = outcomes.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected %p, got %p", want, got);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				it.kind = s_tuser;
				{it.now_ms, it.retry_delay_ms, it.airtime_ms, it.channel, it.ack_req,
					it.packet_id, it.to_node, it.from_node} = s_tdata[163:0];
				predict_item(it);
			end
			if (cfg_we) begin
				if (cfg_index == CFG_OWN_NODE)
					my_node = cfg_data;
				else
					max_tx = cfg_data[3:0];
			end
			queued = outcomes.size();
		end
	end
endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// Retransmission timer table testbench
// Drives directed and random sends, receptions, acks and ticks through several
// register settings, with bursty input and a stalling output, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------
module tb;
	import rttt_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int DRAIN    = 40;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	int          errors;
	int          pending;
	int          idle_cycles;
	bit          hold_off;
	logic [31:0] node_me;
	logic [31:0] clock_ms;
	logic [31:0] ids[$];

	retransmission_timer_table_core u_top (.*);

	rttt_checker u_chk (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Receiver: its own stall pattern, plus a long hold-off on request.
	always @(negedge clk) begin
		int phase;
		if (hold_off)
			m_tready <= 1'b0;
		else begin
			phase = phase + 1;
			if (phase % 200 < 60)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic send_item(logic [1:0] k, logic [31:0] frm, logic [31:0] to,
			logic [31:0] pid, logic want, logic [2:0] ch, logic [15:0] air,
			logic [15:0] dly, logic [31:0] now);
		s_tuser <= k;
		s_tdata <= {4'd0, now, dly, air, ch, want, pid, to, frm};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic gap();
		s_tvalid <= 1'b0;
		repeat ($urandom_range(1, 30))
			@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN)
			@(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_OWN_NODE)
			node_me = v;
	endtask

	function automatic logic [31:0] pick_id();
		if (ids.size() > 0 && $urandom_range(0, 3) != 0)
			return ids[$urandom_range(0, ids.size() - 1)];
		return $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1, 40);
	endfunction

	task automatic random_item();
		int          r;
		logic [31:0] pid;
		logic [31:0] frm;
		r = $urandom_range(0, 99);
		pid = pick_id();
		clock_ms = clock_ms + $urandom_range(0, 300);
		if (r < 40) begin
			if (ids.size() < 24)
				ids.push_back(pid);
			frm = ($urandom_range(0, 2) != 0) ? 32'd0 : ($urandom_range(0, 1) ? node_me : $urandom);
			send_item(K_SEND, frm, $urandom, pid, $urandom_range(0, 5) != 0, 3'($urandom),
				16'($urandom_range(0, 1) ? $urandom_range(0, 50) : $urandom),
				16'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 400)), clock_ms);
		end else if (r < 55) begin
			frm = $urandom_range(0, 2) != 0 ? node_me : $urandom;
			send_item(K_RECV, frm, $urandom, pid, 1'($urandom), 3'($urandom),
				16'($urandom_range(0, 1) ? $urandom_range(0, 50) : $urandom),
				16'($urandom), clock_ms);
		end else if (r < 70) begin
			send_item(K_ACK, $urandom, $urandom_range(0, 3) != 0 ? node_me : $urandom,
				$urandom_range(0, 9) == 0 ? 32'd0 : pid, 1'($urandom), 3'($urandom),
				16'($urandom), 16'($urandom), $urandom);
		end else begin
			send_item(K_TICK, $urandom, $urandom, $urandom, 1'($urandom), 3'($urandom),
				16'($urandom), 16'($urandom),
				$urandom_range(0, 15) == 0 ? $urandom : clock_ms);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_OWN_NODE;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = K_SEND;
		m_tready = 1'b0;
		hold_off = 1'b0;
		idle_cycles = 0;
		node_me = 32'd0;
		clock_ms = 32'd1000;
		repeat (4)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes, full table, implicit ack, acks, wrap of time.
		write_reg(CFG_OWN_NODE, 32'hffff_ffff);
		write_reg(CFG_RETRY_LIMIT, 32'd15);
		send_item(K_TICK, 32'd0, 32'd0, 32'd0, 1'b0, 3'd0, 16'd0, 16'd0, 32'd0);
		for (int i = 0; i < 17; i++)
			send_item(K_SEND, i == 0 ? 32'd0 : 32'(i), 32'd0, 32'(i + 1), 1'b1,
				i[2:0] | 3'd7, 16'hffff, i == 1 ? 16'hffff : 16'd5,
				i == 2 ? 32'hffff_fff0 : 32'd0);
		send_item(K_SEND, 32'd0, 32'd0, 32'd1, 1'b1, 3'd2, 16'd0, 16'd0, 32'hffff_ffff);
		send_item(K_TICK, 32'd0, 32'd0, 32'd0, 1'b0, 3'd0, 16'd0, 16'd0, 32'hffff_ffff);
		send_item(K_RECV, 32'hffff_ffff, 32'd0, 32'd1, 1'b0, 3'd0, 16'hffff, 16'd0, 32'd0);
		send_item(K_ACK, 32'd0, 32'd3, 32'd3, 1'b0, 3'd0, 16'd0, 16'd0, 32'd0);
		send_item(K_ACK, 32'd0, 32'hffff_ffff, 32'd0, 1'b1, 3'd7, 16'd0, 16'd0, 32'd0);
		send_item(K_TICK, 32'd0, 32'd0, 32'd0, 1'b0, 3'd0, 16'd0, 16'd0, 32'h8000_0000);
		drain();

		for (int phase_n = 0; phase_n < 6; phase_n++) begin
			case (phase_n)
				0: begin write_reg(CFG_RETRY_LIMIT, 32'd1); write_reg(CFG_OWN_NODE, 32'd0); end
				1: begin write_reg(CFG_RETRY_LIMIT, 32'd3); write_reg(CFG_OWN_NODE, 32'd7); end
				2: write_reg(CFG_RETRY_LIMIT, 32'hffff_fff0);
				3: begin write_reg(CFG_RETRY_LIMIT, 32'd15); write_reg(CFG_OWN_NODE, $urandom); end
				4: write_reg(CFG_RETRY_LIMIT, 32'd2);
				default: write_reg(CFG_RETRY_LIMIT, $urandom_range(1, 15));
			endcase
			ids.delete();
			for (int n = 0; n < 75; n++) begin
				random_item();
				if (n == 30 && phase_n == 1) begin
					// Long receiver hold-off, timed on its own, while items keep coming.
					fork
						begin
							hold_off = 1'b1;
							repeat (400)
								@(negedge clk);
							hold_off = 1'b0;
						end
					join_none
					for (int j = 0; j < 12; j++)
						random_item();
				end
				if ($urandom_range(0, 5) == 0)
					gap();
			end
			drain();
		end

		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
